// ===== rtl/aarch64_code_relocator_unit_macros.svh =====
// Assertion helpers for the relocator sources; acr_queue is the one that uses them.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef AARCH64_CODE_RELOCATOR_UNIT_MACROS_SVH
`define AARCH64_CODE_RELOCATOR_UNIT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ACR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define ACR_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/acr_pkg.sv =====
package acr_pkg;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_SMALL = 2'd2;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH  = 8'd1;

	localparam logic [9:0]  CAPACITY_RESET = 10'd20;
	localparam logic [31:0] SCRATCH_RESET  = 32'h0000_fe00;

	localparam logic [8:0] OP_MOVZ = 9'h1a5;
	localparam logic [8:0] OP_MOVK = 9'h1e5;

	typedef struct packed {
		logic        expand;
		logic [31:0] word;
		logic [1:0]  status;
		logic [31:0] free_regs;
		logic [4:0]  reg_idx;
		logic [63:0] target;
	} acr_entry_t;

	function automatic logic [31:0] wide_move(logic [8:0] opc, logic [4:0] rd,
		logic [1:0] hw, logic [15:0] imm);
		return {opc, hw, imm, rd};
	endfunction

	function automatic logic [4:0] lowest_index(logic [31:0] m);
		logic [31:0] iso;
		logic [4:0]  idx;
		iso = m & (~m + 32'd1);
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (iso[i]) begin
				idx = idx | 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/acr_ifs.sv =====
interface acr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	logic [63:0] inst_address;
	logic        start_req;
	modport source(output valid, output instruction, output inst_address, output start_req,
		input ready);
	modport sink(input valid, input instruction, input inst_address, input start_req,
		output ready);
endinterface

interface acr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] code_word;
	logic [1:0]  status;
	logic        last;
	logic [31:0] free_regs;
	logic [4:0]  jump_reg;
	logic        no_free_reg;
	modport source(output valid, output code_word, output status, output last,
		output free_regs, output jump_reg, output no_free_reg, input ready);
	modport sink(input valid, input code_word, input status, input last,
		input free_regs, input jump_reg, input no_free_reg, output ready);
endinterface

interface acr_cfg_if import acr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/acr_front.sv =====
module acr_front import acr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	acr_in_if.sink     req,
	acr_cfg_if.sink    cfg,
	input  logic       q_ready,
	output logic       push,
	output acr_entry_t push_entry
);

	logic [9:0]  cap_q;
	logic [31:0] scratch_q;
	logic [31:0] free_mask_q;
	logic [9:0]  words_used_q;

	logic [31:0] inst;
	logic [31:0] top;
	logic        is_stp, is_cmp, is_mov, is_adrp, supported;
	logic [4:0]  clr_reg;
	logic        clr_en;
	logic [31:0] fm_base, fm_new;
	logic [9:0]  wu_base;
	logic [10:0] sum;
	logic        too_small;
	logic [20:0] imm21;
	logic [63:0] off;
	logic [63:0] target;

	assign req.ready = q_ready;
	assign cfg.ready = 1'b1;
	assign push      = req.valid && q_ready;

	assign inst = req.instruction;
	assign top  = inst & 32'hffc0_0000;

	always_comb begin
		is_stp  = 1'b0;
		is_cmp  = 1'b0;
		is_mov  = 1'b0;
		is_adrp = 1'b0;
		priority if (top == 32'ha880_0000 || top == 32'ha980_0000 || top == 32'ha900_0000) begin
			is_stp = 1'b1;
		end else if ((inst & 32'h7fc0_001f) == 32'h6b00_001f) begin
			is_cmp = 1'b1;
		end else if ((inst & 32'h7f80_0000) == 32'h7280_0000 ||
			(inst & 32'h7fe0_ffe0) == 32'h2a00_03e0 ||
			(inst & 32'h7fff_fc00) == 32'h1100_0000 ||
			(inst & 32'h7f80_0000) == 32'h5280_0000 ||
			(inst & 32'hbfe0_0400) == 32'hb840_0400 ||
			(inst & 32'hbfc0_0000) == 32'hb940_0000) begin
			is_mov = 1'b1;
		end else if ((inst & 32'h9f00_0000) == 32'h9000_0000) begin
			is_adrp = 1'b1;
		end else begin
			is_adrp = 1'b0;
		end
	end

	assign supported = is_stp || is_cmp || is_mov || is_adrp;
	assign clr_reg   = is_stp ? inst[9:5] : inst[4:0];
	assign clr_en    = is_stp || is_mov || is_adrp;

	assign fm_base   = req.start_req ? scratch_q : free_mask_q;
	assign wu_base   = req.start_req ? 10'd0 : words_used_q;
	assign fm_new    = clr_en ? (fm_base & ~(32'd1 << clr_reg)) : fm_base;
	assign sum       = {1'b0, wu_base} + (is_adrp ? 11'd4 : 11'd1);
	assign too_small = sum > {1'b0, cap_q};

	assign imm21  = {inst[23:5], inst[30:29]};
	assign off    = {{31{imm21[20]}}, imm21, 12'h000};
	assign target = {req.inst_address[63:12], 12'h000} + off;

	always_comb begin
		push_entry.reg_idx = inst[4:0];
		push_entry.target  = target;
		if (!supported) begin
			push_entry.expand    = 1'b0;
			push_entry.word      = '0;
			push_entry.status    = ST_UNSUP;
			push_entry.free_regs = fm_base;
		end else if (too_small) begin
			push_entry.expand    = 1'b0;
			push_entry.word      = '0;
			push_entry.status    = ST_SMALL;
			push_entry.free_regs = fm_new;
		end else begin
			push_entry.expand    = is_adrp;
			push_entry.word      = inst;
			push_entry.status    = ST_OK;
			push_entry.free_regs = fm_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAPACITY_RESET;
			scratch_q    <= SCRATCH_RESET;
			free_mask_q  <= SCRATCH_RESET;
			words_used_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_CAPACITY: cap_q     <= cfg.data[9:0];
					CFG_SCRATCH:  scratch_q <= cfg.data;
					default:      cap_q     <= cap_q;
				endcase
			end
			if (push) begin
				free_mask_q  <= supported ? fm_new : fm_base;
				words_used_q <= (supported && !too_small) ? sum[9:0] : wu_base;
			end
		end
	end

endmodule

// ===== rtl/acr_queue.sv =====
`include "aarch64_code_relocator_unit_macros.svh"

module acr_queue import acr_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  acr_entry_t push_entry,
	output logic       not_full,
	input  logic       pop,
	output logic       head_valid,
	output acr_entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	acr_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full   = count_q != CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ACR_NEVER(a_push_when_full, push && !not_full, "push into a full queue")
	`ACR_NEVER(a_pop_when_empty, pop && !head_valid, "pop from an empty queue")
	`ACR_ASSERT(a_count_grows, (push && !pop) |=> count_q == $past(count_q) + 1'b1, "count did not grow")

endmodule

// ===== rtl/acr_back.sv =====
module acr_back import acr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  acr_entry_t head,
	output logic       pop,
	acr_out_if.source  rsp
);

	logic        valid_q;
	logic [1:0]  beat_q;
	logic        load;
	logic        last_beat;
	logic [15:0] slice;
	logic [31:0] word;
	logic [31:0] code_word_q;
	logic [1:0]  status_q;
	logic        last_q;
	logic [31:0] free_regs_q;
	logic [4:0]  jump_reg_q;
	logic        no_free_q;

	assign load      = head_valid && (!valid_q || rsp.ready);
	assign last_beat = !head.expand || beat_q == 2'd3;
	assign pop       = load && last_beat;

	always_comb begin
		unique case (beat_q)
			2'd0: slice = head.target[63:48];
			2'd1: slice = head.target[47:32];
			2'd2: slice = head.target[31:16];
			2'd3: slice = head.target[15:0];
			default: slice = head.target[15:0];
		endcase
	end

	assign word = head.expand ?
		wide_move((beat_q == 2'd0) ? OP_MOVZ : OP_MOVK, head.reg_idx, ~beat_q, slice) :
		head.word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= last_beat ? 2'd0 : beat_q + 2'd1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_word_q <= word;
			status_q    <= head.status;
			last_q      <= last_beat;
			free_regs_q <= head.free_regs;
			jump_reg_q  <= lowest_index(head.free_regs);
			no_free_q   <= head.free_regs == '0;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.code_word   = code_word_q;
	assign rsp.status      = status_q;
	assign rsp.last        = last_q;
	assign rsp.free_regs   = free_regs_q;
	assign rsp.jump_reg    = jump_reg_q;
	assign rsp.no_free_reg = no_free_q;

endmodule

// ===== rtl/aarch64_code_relocator_unit.sv =====
// The relocator takes one instruction beat per cycle on req while its queue has room, and
// returns one or more result beats on rsp, the final one marked by last. STP, CMP, MOV, MOVK
// and LDR forms, unsupported words and buffer-full reports give a single result beat; ADRP
// gives four (MOVZ then three MOVK), so an ADRP holds the output until all four of its beats
// are taken, stepped by the output beat counter. Other instructions are served at one per
// cycle while rsp is ready. The first result beat is offered on rsp once its instruction has
// been written into the queue and then loaded into the output registers. A small queue
// between the decoder and the output stage lets req keep taking beats while rsp is stalled,
// until the queue fills. Register writes on cfg are always accepted and should only be made
// while no result is outstanding.
module aarch64_code_relocator_unit import acr_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	acr_in_if.sink    req,
	acr_out_if.source rsp,
	acr_cfg_if.sink   cfg
);

	logic       push, not_full, pop, head_valid;
	acr_entry_t push_entry, head;

	acr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.q_ready    (not_full),
		.push       (push),
		.push_entry (push_entry)
	);

	acr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (not_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	acr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
